>>> rtl/core/hcbd_pkg.sv
// Shared types, codes and character helpers for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = 2;
   localparam int QCNT_BITS = 3;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_REST,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NO_SIZE_CRLF  = 2'd0,
      ERR_BAD_SIZE      = 2'd1,
      ERR_OVERRUN       = 2'd2,
      ERR_NO_CHUNK_CRLF = 2'd3
   } err_code_type;

   typedef enum logic [1:0] {
      ST_NONE,
      ST_COMPLETE,
      ST_ERROR
   } status_type;

   typedef struct packed {
      kind_type     kind;
      logic [7:0]   out_byte;
      err_code_type error_code;
      logic         final_res;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   // Returns a valid flag above the four-bit digit value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      hex_digit = r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/hcbd_if.sv
// Request and result channel interfaces of the chunked body decoder.
`default_nettype none

interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_body;

   modport source (output valid, output data_byte, output end_of_body, input ready);
   modport sink (input valid, input data_byte, input end_of_body, output ready);
endinterface

interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [1:0] error_code;
   logic       final_res;

   modport source (output valid, output kind, output out_byte, output error_code,
                   output final_res, input ready);
   modport sink (input valid, input kind, input out_byte, input error_code,
                 input final_res, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hcbd_parser.sv
// Chunk framing state machine that turns one body byte into up to two results.
`default_nettype none

module hcbd_parser
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       end_of_body,
   output push_type   push
);

   typedef struct packed {
      phase_type            phase;
      logic [SIZE_BITS-1:0] count;
      logic                 digit;
      logic                 invalid;
   } line_type;

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] count_ff, count_in;
   logic                 digit_ff, digit_in;
   logic                 invalid_ff, invalid_in;
   logic                 prev_cr_ff, prev_cr_in;

   line_type             line_cur, line_mid, line_next;
   logic [SIZE_BITS-1:0] count_dec;
   status_type           status;
   err_code_type         err_code;
   logic                 emit_byte;
   rsp_item_type         byte_item, status_item;

   function automatic line_type line_step(input line_type s, input logic [7:0] c);
      line_type   r;
      logic [4:0] hd;
      r  = s;
      hd = hex_digit(c);
      case (s.phase)
         PH_LEAD: begin
            if (!is_space(c)) begin
               if (hd[4]) begin
                  r.digit = 1'b1;
                  r.count = SIZE_BITS'(hd[3:0]);
                  r.phase = PH_DIGITS;
               end else begin
                  r.invalid = 1'b1;
                  r.phase   = PH_REST;
               end
            end
         end
         PH_DIGITS: begin
            if (!hd[4]) begin
               r.phase = PH_REST;
            end else if (s.count[SIZE_BITS-1 -: 4] != 4'd0) begin
               r.invalid = 1'b1;
               r.phase   = PH_REST;
            end else begin
               r.count = {s.count[SIZE_BITS-5:0], hd[3:0]};
            end
         end
         default: begin
         end
      endcase
      line_step = r;
   endfunction

   // A held CR is replayed as an ordinary line character before the new byte.
   always_comb begin
      line_cur.phase   = phase_ff;
      line_cur.count   = count_ff;
      line_cur.digit   = digit_ff;
      line_cur.invalid = invalid_ff;
      line_mid  = prev_cr_ff ? line_step(line_cur, CHAR_CR) : line_cur;
      line_next = (data_byte == CHAR_CR) ? line_mid : line_step(line_mid, data_byte);
      count_dec = count_ff - SIZE_BITS'(1);
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      digit_in   = digit_ff;
      invalid_in = invalid_ff;
      prev_cr_in = prev_cr_ff;
      status     = ST_NONE;
      err_code   = ERR_NO_SIZE_CRLF;
      emit_byte  = 1'b0;
      if (accept) begin
         unique case (phase_ff) inside
            PH_LEAD, PH_DIGITS, PH_REST: begin
               if (prev_cr_ff && data_byte == CHAR_LF) begin
                  prev_cr_in = 1'b0;
                  if (invalid_ff || !digit_ff) begin
                     status   = ST_ERROR;
                     err_code = ERR_BAD_SIZE;
                  end else if (count_ff == '0) begin
                     status = ST_COMPLETE;
                  end else begin
                     phase_in = PH_DATA;
                     if (end_of_body) begin
                        status   = ST_ERROR;
                        err_code = ERR_OVERRUN;
                     end
                  end
               end else begin
                  phase_in   = line_next.phase;
                  count_in   = line_next.count;
                  digit_in   = line_next.digit;
                  invalid_in = line_next.invalid;
                  prev_cr_in = (data_byte == CHAR_CR);
                  if (end_of_body) begin
                     status   = ST_ERROR;
                     err_code = ERR_NO_SIZE_CRLF;
                  end
               end
            end
            PH_DATA: begin
               emit_byte = 1'b1;
               count_in  = count_dec;
               if (count_dec == '0) begin
                  phase_in = PH_DATA_CR;
               end
               if (end_of_body) begin
                  status   = ST_ERROR;
                  err_code = (count_dec != '0) ? ERR_OVERRUN : ERR_NO_CHUNK_CRLF;
               end
            end
            PH_DATA_CR: begin
               if (data_byte != CHAR_CR || end_of_body) begin
                  status   = ST_ERROR;
                  err_code = ERR_NO_CHUNK_CRLF;
               end else begin
                  phase_in = PH_DATA_LF;
               end
            end
            PH_DATA_LF: begin
               if (data_byte != CHAR_LF) begin
                  status   = ST_ERROR;
                  err_code = ERR_NO_CHUNK_CRLF;
               end else begin
                  phase_in   = PH_LEAD;
                  count_in   = '0;
                  digit_in   = 1'b0;
                  invalid_in = 1'b0;
                  prev_cr_in = 1'b0;
                  if (end_of_body) begin
                     status   = ST_ERROR;
                     err_code = ERR_NO_SIZE_CRLF;
                  end
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
         if (status != ST_NONE) begin
            phase_in = PH_DONE;
         end
         if (end_of_body) begin
            phase_in   = PH_LEAD;
            count_in   = '0;
            digit_in   = 1'b0;
            invalid_in = 1'b0;
            prev_cr_in = 1'b0;
         end
      end
   end

   always_comb begin
      byte_item.kind          = KIND_BYTE;
      byte_item.out_byte      = data_byte;
      byte_item.error_code    = ERR_NO_SIZE_CRLF;
      byte_item.final_res     = 1'b0;
      status_item.kind        = (status == ST_COMPLETE) ? KIND_DONE : KIND_ERROR;
      status_item.out_byte    = 8'd0;
      status_item.error_code  = (status == ST_COMPLETE) ? ERR_NO_SIZE_CRLF : err_code;
      status_item.final_res   = 1'b1;
      if (emit_byte) begin
         push.first  = byte_item;
         push.second = status_item;
         push.count  = (status != ST_NONE) ? 2'd2 : 2'd1;
      end else begin
         push.first  = status_item;
         push.second = status_item;
         push.count  = (status != ST_NONE) ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         count_ff   <= '0;
         digit_ff   <= 1'b0;
         invalid_ff <= 1'b0;
         prev_cr_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         digit_ff   <= digit_in;
         invalid_ff <= invalid_in;
         prev_cr_ff <= prev_cr_in;
      end
   end

   a_two_results_shape: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.kind == KIND_BYTE && push.second.final_res)
      else $error("two results must be a payload byte followed by a status");

   a_eob_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_body |=> phase_ff == PH_LEAD && !prev_cr_ff && count_ff == '0)
      else $error("last byte of a body must restart the size line");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_DONE && !end_of_body |=> phase_ff == PH_DONE && push.count == 2'd0)
      else $error("bytes after a final status must be ignored");

   a_no_push_when_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.count == 2'd0)
      else $error("results produced without an accepted request");

endmodule

`default_nettype wire

>>> rtl/core/hcbd_rsp_queue.sv
// Four-entry result queue that takes up to two results a cycle and sends one while the receiver is ready.
`default_nettype none

module hcbd_rsp_queue
   import hcbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   output logic              space_ok,
   hcbd_rsp_if.source        rsp_chan
);

   rsp_item_type             mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]     count_ff, count_in;
   logic                     pop;
   rsp_item_type             head;

   assign head     = mem_ff[rd_ptr_ff];
   assign pop      = (count_ff != '0) && rsp_chan.ready;
   assign space_ok = (count_ff <= QCNT_BITS'(QDEPTH - 2));

   assign rsp_chan.valid      = (count_ff != '0);
   assign rsp_chan.kind       = head.kind;
   assign rsp_chan.out_byte   = head.out_byte;
   assign rsp_chan.error_code = head.error_code;
   assign rsp_chan.final_res  = head.final_res;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      count_in  = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QPTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QDEPTH))
      else $error("result queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= QCNT_BITS'(QDEPTH - 2))
      else $error("results pushed without room for two entries");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - QCNT_BITS'(1))
      else $error("a send without a push must lower the fill by one");

endmodule

`default_nettype wire

>>> rtl/core/http_chunked_body_decoder_unit.sv
// Top level of the chunked HTTP body decoder.
// The request channel carries one raw body byte per request, with end_of_body
// set on the last byte of each body. The result channel carries payload bytes
// (kind 0) and exactly one final status per body: complete (kind 1) or an
// error (kind 2) with its error code; the consumer drops the payload of a
// body that ends in an error. Bytes after a final status are ignored up to
// end_of_body, which always starts a new body.
// Each request is decoded in the cycle it is accepted and its results are
// written into a four-entry result queue, so the first result of a request
// that reaches an empty queue is visible in the next cycle. One request is
// accepted per cycle while ready is high; a request that gives a payload
// byte and a status puts two results in the queue, which are sent in order.
// When the receiver stalls, the queue fills and ready drops once more than
// two results are waiting; no result is lost. Reset empties the queue and
// returns the decoder to the start of a chunk-size line.
`default_nettype none

module http_chunked_body_decoder_unit
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   hcbd_req_if.sink   req_chan,
   hcbd_rsp_if.source rsp_chan
);

   logic     space_ok;
   logic     req_accept;
   push_type push;

   assign req_chan.ready = space_ok;
   assign req_accept     = req_chan.valid && space_ok;

   hcbd_parser #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_chan.data_byte),
      .end_of_body (req_chan.end_of_body),
      .push        (push)
   );

   hcbd_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sim/http_chunked_body_decoder_unit_tb.sv
// Self-checking testbench for the chunked HTTP body decoder with random stalls on both channels.
`timescale 1ns / 100ps

module http_chunked_body_decoder_unit_tb
   import hcbd_pkg::*;
();

   localparam int SIZE_W      = 32;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_BYTES = 250;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_body;
   } body_byte_type;

   logic clock = 1'b0;
   logic reset;

   hcbd_req_if req_if ();
   hcbd_rsp_if rsp_if ();

   http_chunked_body_decoder_unit #(.SIZE_BITS(SIZE_W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   body_byte_type tx_bytes[$];
   logic [7:0]    draft[$];
   rsp_item_type  expected_rsp[$];

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int fail_count      = 0;
   int byte_total      = 0;
   int cycle_count     = 0;

   phase_type         line_phase;
   logic [SIZE_W-1:0] chunk_left;
   logic              size_digit_seen;
   logic              size_bad;
   logic              cr_held;

   always #5 clock = ~clock;

   function automatic int hex_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c) - int'("0");
      end else if (c >= "a" && c <= "f") begin
         return int'(c) - int'("a") + 10;
      end else if (c >= "A" && c <= "F") begin
         return int'(c) - int'("A") + 10;
      end
      return -1;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == " ") || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   task automatic start_size_line();
      line_phase      = PH_LEAD;
      chunk_left      = '0;
      size_digit_seen = 1'b0;
      size_bad        = 1'b0;
      cr_held         = 1'b0;
   endtask

   task automatic size_line_char(input logic [7:0] c);
      int v;
      v = hex_val(c);
      if (line_phase == PH_LEAD) begin
         if (!is_blank(c)) begin
            if (v >= 0) begin
               size_digit_seen = 1'b1;
               chunk_left      = SIZE_W'(v);
               line_phase      = PH_DIGITS;
            end else begin
               size_bad   = 1'b1;
               line_phase = PH_REST;
            end
         end
      end else if (line_phase == PH_DIGITS) begin
         if (v < 0) begin
            line_phase = PH_REST;
         end else if (chunk_left[SIZE_W-1 -: 4] != 4'd0) begin
            size_bad   = 1'b1;
            line_phase = PH_REST;
         end else begin
            chunk_left = {chunk_left[SIZE_W-5:0], 4'(v)};
         end
      end
   endtask

   task automatic expect_result(input kind_type kind, input logic [7:0] data,
                                input err_code_type code, input logic fin);
      rsp_item_type r;
      r            = '0;
      r.kind       = kind;
      r.out_byte   = data;
      r.error_code = code;
      r.final_res  = fin;
      expected_rsp.push_back(r);
   endtask

   task automatic decode_body_byte(input logic [7:0] c, input logic eob);
      logic         ends_body;
      kind_type     end_kind;
      err_code_type end_code;
      ends_body = 1'b0;
      end_kind  = KIND_ERROR;
      end_code  = ERR_NO_SIZE_CRLF;
      case (line_phase) inside
         PH_LEAD, PH_DIGITS, PH_REST: begin
            if (cr_held && c == CHAR_LF) begin
               cr_held = 1'b0;
               if (size_bad || !size_digit_seen) begin
                  ends_body = 1'b1;
                  end_code  = ERR_BAD_SIZE;
               end else if (chunk_left == '0) begin
                  ends_body = 1'b1;
                  end_kind  = KIND_DONE;
               end else begin
                  line_phase = PH_DATA;
                  if (eob) begin
                     ends_body = 1'b1;
                     end_code  = ERR_OVERRUN;
                  end
               end
            end else begin
               if (cr_held) begin
                  cr_held = 1'b0;
                  size_line_char(CHAR_CR);
               end
               if (c == CHAR_CR) begin
                  cr_held = 1'b1;
               end else begin
                  size_line_char(c);
               end
               if (eob) begin
                  ends_body = 1'b1;
                  end_code  = ERR_NO_SIZE_CRLF;
               end
            end
         end
         PH_DATA: begin
            expect_result(KIND_BYTE, c, ERR_NO_SIZE_CRLF, 1'b0);
            chunk_left = chunk_left - SIZE_W'(1);
            if (chunk_left == '0) begin
               line_phase = PH_DATA_CR;
            end
            if (eob) begin
               ends_body = 1'b1;
               end_code  = (chunk_left != '0) ? ERR_OVERRUN : ERR_NO_CHUNK_CRLF;
            end
         end
         PH_DATA_CR: begin
            if (c != CHAR_CR || eob) begin
               ends_body = 1'b1;
               end_code  = ERR_NO_CHUNK_CRLF;
            end else begin
               line_phase = PH_DATA_LF;
            end
         end
         PH_DATA_LF: begin
            if (c != CHAR_LF) begin
               ends_body = 1'b1;
               end_code  = ERR_NO_CHUNK_CRLF;
            end else begin
               start_size_line();
               if (eob) begin
                  ends_body = 1'b1;
                  end_code  = ERR_NO_SIZE_CRLF;
               end
            end
         end
         default: begin
         end
      endcase
      if (ends_body) begin
         if (end_kind == KIND_DONE) begin
            expect_result(KIND_DONE, 8'h00, ERR_NO_SIZE_CRLF, 1'b1);
         end else begin
            expect_result(KIND_ERROR, 8'h00, end_code, 1'b1);
         end
         line_phase = PH_DONE;
      end
      if (eob) begin
         start_size_line();
      end
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         draft.push_back(s[i]);
      end
   endtask

   task automatic put_crlf();
      draft.push_back(CHAR_CR);
      draft.push_back(CHAR_LF);
   endtask

   task automatic put_hex(input logic [SIZE_W-1:0] value);
      int         top;
      logic [3:0] nib;
      top = 0;
      for (int i = 0; i < SIZE_W / 4; i++) begin
         if (value[4*i +: 4] != 4'd0) begin
            top = i;
         end
      end
      for (int i = top; i >= 0; i--) begin
         nib = value[4*i +: 4];
         if (nib < 4'd10) begin
            draft.push_back(8'("0") + 8'(nib));
         end else if ($urandom_range(1) == 0) begin
            draft.push_back(8'("a") + 8'(nib) - 8'd10);
         end else begin
            draft.push_back(8'("A") + 8'(nib) - 8'd10);
         end
      end
   endtask

   function automatic logic [7:0] odd_char();
      case ($urandom_range(7))
         0: return CHAR_CR;
         1: return CHAR_LF;
         2: return ";";
         3: return "0";
         4: return "a";
         5: return "g";
         6: return CHAR_SPACE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic add_size_line(input logic [SIZE_W-1:0] value);
      case ($urandom_range(5))
         0: draft.push_back(CHAR_SPACE);
         1: draft.push_back(CHAR_TAB);
         2: draft.push_back(8'($urandom_range(1) ? CHAR_LF : $urandom_range(11, 12)));
         3: begin
            draft.push_back(CHAR_CR);
            draft.push_back(CHAR_SPACE);
         end
         default: begin
         end
      endcase
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) draft.push_back("0");
      end
      put_hex(value);
      case ($urandom_range(5))
         0: put_text(";x=1");
         1: put_text(" ;y");
         2: begin
            draft.push_back(CHAR_CR);
            draft.push_back(";");
         end
         3: draft.push_back(CHAR_SPACE);
         default: begin
         end
      endcase
      put_crlf();
   endtask

   task automatic add_odd_line();
      case ($urandom_range(7))
         0: put_text("-5");
         1: put_text("+1");
         2: put_text(";");
         3: begin
         end
         4: put_text("0x1f");
         5: put_text("1FFFFFFFF");
         6: put_text("FFFFFFFF");
         default: put_text("00000000fffffffe");
      endcase
      put_crlf();
   endtask

   task automatic send_draft();
      body_byte_type b;
      for (int i = 0; i < draft.size(); i++) begin
         b.data_byte   = draft[i];
         b.end_of_body = (i == draft.size() - 1);
         tx_bytes.push_back(b);
      end
      byte_total += draft.size();
      draft.delete();
   endtask

   task automatic add_random_body();
      int len;
      int pick;
      int cut;
      pick = $urandom_range(99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 10)) draft.push_back(odd_char());
      end else begin
         if (pick < 14) begin
            add_odd_line();
         end
         repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            add_size_line(SIZE_W'(len));
            repeat (len) draft.push_back(8'($urandom_range(255)));
            put_crlf();
         end
         add_size_line('0);
         repeat ($urandom_range(0, 3)) draft.push_back(8'($urandom_range(255)));
         pick = $urandom_range(99);
         if (pick < 14) begin
            cut = $urandom_range(1, draft.size());
            while (draft.size() > cut) begin
               draft.delete(draft.size() - 1);
            end
         end else if (pick < 24) begin
            draft[$urandom_range(draft.size() - 1)] = odd_char();
         end
      end
      send_draft();
   endtask

   task automatic add_directed();
      draft.push_back(CHAR_TAB);
      put_text("2;x");
      put_crlf();
      draft.push_back(8'h00);
      draft.push_back(8'hFF);
      put_crlf();
      put_text("0");
      put_crlf();
      put_text("T");
      send_draft();
      put_text("0x");
      put_crlf();
      send_draft();
      put_text("-");
      put_crlf();
      send_draft();
      put_text("5");
      send_draft();
      put_text("1");
      put_crlf();
      put_text("z");
      send_draft();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (tx_bytes.size() != 0 || req_if.valid || expected_rsp.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic check_result();
      rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         $error("unexpected result: kind %0d, out_byte %0h", rsp_if.kind, rsp_if.out_byte);
         fail_count++;
      end else begin
         want = expected_rsp.pop_front();
         if (rsp_if.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, rsp_if.kind);
            fail_count++;
         end
         if (rsp_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, rsp_if.out_byte);
            fail_count++;
         end
         if (rsp_if.error_code !== want.error_code) begin
            $error("error_code: expected %0d, actual %0d", want.error_code, rsp_if.error_code);
            fail_count++;
         end
         if (rsp_if.final_res !== want.final_res) begin
            $error("final_res: expected %0d, actual %0d", want.final_res, rsp_if.final_res);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin : request_driver
      body_byte_type next_req;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            decode_body_byte(req_if.data_byte, req_if.end_of_body);
         end
         if (!req_if.valid || req_if.ready) begin
            if (tx_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_req = tx_bytes.pop_front();
               req_if.valid       <= 1'b1;
               req_if.data_byte   <= next_req.data_byte;
               req_if.end_of_body <= next_req.end_of_body;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_result();
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int mark;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_byte   = 8'h00;
      req_if.end_of_body = 1'b0;
      rsp_if.ready       = 1'b0;
      start_size_line();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 0;
               add_directed();
            end
            1: begin
               sender_idle_pct = 68;
               recv_stall_pct  = 0;
            end
            2: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 68;
            end
            default: begin
               sender_idle_pct = 6;
               recv_stall_pct  = 6;
            end
         endcase
         mark = byte_total;
         while (byte_total - mark < PHASE_BYTES) begin
            add_random_body();
         end
         wait_drained();
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
